// File: hdl/mpba_pkg.sv
// shared constants, types and state codes of the multi-pool block allocator
// no dependencies; every other file but mpba_ram refers to it by scoped names
package mpba_pkg;

  // sizing
  localparam int POOL_COUNT  = 4;
  localparam int MAX_ENTRIES = 256;
  localparam int POOL_SLOTS  = 4;
  localparam int POOL_W      = 2;
  localparam int LAST_POOL   = POOL_COUNT - 1;

  // field widths
  localparam int CMD_W    = 2;
  localparam int LEN_W    = 16;
  localparam int HANDLE_W = 8;
  localparam int BYTES_W  = 16;
  localparam int COUNT_W  = 9;

  // derived widths
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W  = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
  localparam int OPND_W = (SUM_W > BYTES_W) ? SUM_W : BYTES_W;
  localparam int LINK_W = IDX_W + 1;

  // register port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT = 2'd0,
    CMD_GET  = 2'd1,
    CMD_FREE = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_P0_BYTES = 3'd0,
    REG_P1_BYTES = 3'd1,
    REG_P2_BYTES = 3'd2,
    REG_P3_BYTES = 3'd3,
    REG_P0_COUNT = 3'd4,
    REG_P1_COUNT = 3'd5,
    REG_P2_COUNT = 3'd6,
    REG_P3_COUNT = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GET_SCAN,
    S_GET_POP,
    S_FREE_READ,
    S_FREE_LINK,
    S_INIT_POOL,
    S_INIT_FILL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [POOL_SLOTS-1:0][BYTES_W-1:0] block_bytes;
    logic [POOL_SLOTS-1:0][COUNT_W-1:0] entry_count;
  } cfg_t;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] handle;
    logic [POOL_W-1:0]   pool;
  } result_t;

endpackage

// File: hdl/mpba_if.sv
// request and response channel interfaces of the block allocator
// depends on mpba_pkg for field widths
interface mpba_req_if;
  logic                          valid;
  logic                          ready;
  logic [mpba_pkg::CMD_W-1:0]    cmd;
  logic [mpba_pkg::LEN_W-1:0]    req_length;
  logic [mpba_pkg::HANDLE_W-1:0] free_handle;

  modport source (output valid, cmd, req_length, free_handle, input ready);
  modport sink (input valid, cmd, req_length, free_handle, output ready);
endinterface

interface mpba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [mpba_pkg::HANDLE_W-1:0] grant_handle;
  logic [mpba_pkg::POOL_W-1:0]   grant_pool;

  modport source (output valid, ok, grant_handle, grant_pool, input ready);
  modport sink (input valid, ok, grant_handle, grant_pool, output ready);
endinterface

// File: hdl/mpba_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module mpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/mpba_cmp.sv
// shared magnitude compare unit used by every command of the sequencer
// depends on mpba_pkg for the operand width
module mpba_cmp (
  input  logic [mpba_pkg::OPND_W-1:0] op_a,
  input  logic [mpba_pkg::OPND_W-1:0] op_b,
  output logic                        ge
);

  logic [mpba_pkg::OPND_W:0] diff;

  // no borrow out means op_a >= op_b
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[mpba_pkg::OPND_W];

endmodule

// File: hdl/mpba_cfg.sv
// apb-style register file holding buffer sizes and entry counts per pool
// depends on mpba_pkg for the register map and the cfg_t struct
module mpba_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpba_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpba_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpba_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output mpba_pkg::cfg_t                  cfg
);

  mpba_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = mpba_pkg::reg_idx_t'(paddr[mpba_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        mpba_pkg::REG_P0_BYTES: cfg.block_bytes[0] <= pwdata[mpba_pkg::BYTES_W-1:0];
        mpba_pkg::REG_P1_BYTES: cfg.block_bytes[1] <= pwdata[mpba_pkg::BYTES_W-1:0];
        mpba_pkg::REG_P2_BYTES: cfg.block_bytes[2] <= pwdata[mpba_pkg::BYTES_W-1:0];
        mpba_pkg::REG_P3_BYTES: cfg.block_bytes[3] <= pwdata[mpba_pkg::BYTES_W-1:0];
        mpba_pkg::REG_P0_COUNT: cfg.entry_count[0] <= pwdata[mpba_pkg::COUNT_W-1:0];
        mpba_pkg::REG_P1_COUNT: cfg.entry_count[1] <= pwdata[mpba_pkg::COUNT_W-1:0];
        mpba_pkg::REG_P2_COUNT: cfg.entry_count[2] <= pwdata[mpba_pkg::COUNT_W-1:0];
        mpba_pkg::REG_P3_COUNT: cfg.entry_count[3] <= pwdata[mpba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mpba_pkg::REG_P0_BYTES: prdata = mpba_pkg::APB_DATA_W'(cfg.block_bytes[0]);
      mpba_pkg::REG_P1_BYTES: prdata = mpba_pkg::APB_DATA_W'(cfg.block_bytes[1]);
      mpba_pkg::REG_P2_BYTES: prdata = mpba_pkg::APB_DATA_W'(cfg.block_bytes[2]);
      mpba_pkg::REG_P3_BYTES: prdata = mpba_pkg::APB_DATA_W'(cfg.block_bytes[3]);
      mpba_pkg::REG_P0_COUNT: prdata = mpba_pkg::APB_DATA_W'(cfg.entry_count[0]);
      mpba_pkg::REG_P1_COUNT: prdata = mpba_pkg::APB_DATA_W'(cfg.entry_count[1]);
      mpba_pkg::REG_P2_COUNT: prdata = mpba_pkg::APB_DATA_W'(cfg.entry_count[2]);
      mpba_pkg::REG_P3_COUNT: prdata = mpba_pkg::APB_DATA_W'(cfg.entry_count[3]);
      default: prdata = '0;
    endcase
  end

endmodule

// File: hdl/multi_pool_block_allocator_core.sv
// top level of the multi-pool block allocator: sequencer, free-list state, link memories
// depends on mpba_pkg, mpba_if, mpba_ram, mpba_cmp and mpba_cfg
//
// usage
//   req channel (valid/ready) carries one command transaction: init, get or free.
//   rsp channel (valid/ready) returns exactly one result transaction per command:
//   ok, grant_handle, grant_pool. the apb port sets buffer size and entry count per
//   pool; write it only while no command is in flight, then issue init.
// timing
//   one command at a time: req.ready is high only while the sequencer is idle.
//   get: the scan examines one pool per cycle (single shared comparator), then the
//   link memory read and the result staging follow before rsp.valid.
//   free: pool memory read, clear of the new tail link, append to the old tail,
//   result staging, then rsp.valid.
//   init: a capacity check per pool plus one link write per entry built.
//   a bad free handle or the unused command code goes straight to result staging.
// reset
//   synchronous, active high; every pool is empty, registers read zero. link and
//   pool memories are not cleared: init writes every entry it hands out.
// stall
//   the result sits in an output register; the block returns to idle once it is loaded.
//   a stalled receiver holds only the next result in the result stage, req.ready low.
module multi_pool_block_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  mpba_req_if.sink                        req,
  mpba_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpba_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpba_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpba_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  mpba_pkg::cfg_t   cfg;
  mpba_pkg::state_t state, state_next;

  // per-command working registers
  logic [mpba_pkg::LEN_W-1:0]  len_q, len_q_next;
  logic [mpba_pkg::IDX_W-1:0]  handle_q, handle_q_next;
  logic [mpba_pkg::POOL_W-1:0] pool_q, pool_q_next;
  logic [mpba_pkg::CNT_W-1:0]  base_q, base_q_next;
  logic [mpba_pkg::IDX_W-1:0]  fill_idx, fill_idx_next;
  mpba_pkg::result_t           res_q, res_q_next;

  // free-list heads, tails and occupancy per pool
  logic [mpba_pkg::IDX_W-1:0] head [mpba_pkg::POOL_SLOTS];
  logic [mpba_pkg::IDX_W-1:0] head_next [mpba_pkg::POOL_SLOTS];
  logic [mpba_pkg::IDX_W-1:0] tail [mpba_pkg::POOL_SLOTS];
  logic [mpba_pkg::IDX_W-1:0] tail_next [mpba_pkg::POOL_SLOTS];
  logic [mpba_pkg::POOL_SLOTS-1:0] nonempty, nonempty_next;

  // output register
  logic              rsp_valid;
  mpba_pkg::result_t rsp_data;
  logic              rsp_load;

  // link memory: {valid, successor}
  logic                        link_we;
  logic [mpba_pkg::IDX_W-1:0]  link_waddr, link_raddr;
  logic [mpba_pkg::LINK_W-1:0] link_wdata, link_rdata;

  // pool memory: pool each entry was built into
  logic                        pool_we;
  logic [mpba_pkg::IDX_W-1:0]  pool_waddr, pool_raddr;
  logic [mpba_pkg::POOL_W-1:0] pool_wdata, pool_rdata;

  // shared comparator
  logic [mpba_pkg::OPND_W-1:0] cmp_a, cmp_b;
  logic                        cmp_ge;

  logic                        req_acc;
  logic [mpba_pkg::SUM_W-1:0]  init_sum;
  logic                        last_pool;

  mpba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpba_ram #(
    .WIDTH (mpba_pkg::LINK_W),
    .DEPTH (mpba_pkg::MAX_ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  mpba_ram #(
    .WIDTH (mpba_pkg::POOL_W),
    .DEPTH (mpba_pkg::MAX_ENTRIES)
  ) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  mpba_cmp u_cmp (
    .op_a (cmp_a),
    .op_b (cmp_b),
    .ge   (cmp_ge)
  );

  assign req.ready = (state == mpba_pkg::S_IDLE);
  assign req_acc   = req.valid & req.ready;

  // running entry number after the current pool during init
  assign init_sum  = mpba_pkg::SUM_W'(base_q) + mpba_pkg::SUM_W'(cfg.entry_count[pool_q]);
  assign last_pool = (pool_q == mpba_pkg::POOL_W'(mpba_pkg::LAST_POOL));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mpba_pkg::S_IDLE;
      nonempty <= '0;
      for (int i = 0; i < mpba_pkg::POOL_SLOTS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      state    <= state_next;
      nonempty <= nonempty_next;
      head     <= head_next;
      tail     <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    len_q    <= len_q_next;
    handle_q <= handle_q_next;
    pool_q   <= pool_q_next;
    base_q   <= base_q_next;
    fill_idx <= fill_idx_next;
    res_q    <= res_q_next;
  end

  always_comb begin
    state_next    = state;
    len_q_next    = len_q;
    handle_q_next = handle_q;
    pool_q_next   = pool_q;
    base_q_next   = base_q;
    fill_idx_next = fill_idx;
    res_q_next    = res_q;
    head_next     = head;
    tail_next     = tail;
    nonempty_next = nonempty;
    link_we       = 1'b0;
    link_waddr    = '0;
    link_wdata    = '0;
    link_raddr    = '0;
    pool_we       = 1'b0;
    pool_waddr    = '0;
    pool_wdata    = '0;
    pool_raddr    = '0;
    cmp_a         = '0;
    cmp_b         = '0;
    rsp_load      = 1'b0;

    unique case (state)
      mpba_pkg::S_IDLE: begin
        if (req_acc) begin
          len_q_next    = req.req_length;
          handle_q_next = mpba_pkg::IDX_W'(req.free_handle);
          pool_q_next   = '0;
          unique case (mpba_pkg::cmd_t'(req.cmd))
            mpba_pkg::CMD_INIT: begin
              // every list is emptied before the build walk
              nonempty_next = '0;
              for (int i = 0; i < mpba_pkg::POOL_SLOTS; i++) begin
                head_next[i] = '0;
                tail_next[i] = '0;
              end
              base_q_next = '0;
              state_next  = mpba_pkg::S_INIT_POOL;
            end
            mpba_pkg::CMD_GET: begin
              state_next = mpba_pkg::S_GET_SCAN;
            end
            mpba_pkg::CMD_FREE: begin
              // handles past the memory are dropped
              cmp_a = mpba_pkg::OPND_W'(req.free_handle);
              cmp_b = mpba_pkg::OPND_W'(mpba_pkg::MAX_ENTRIES);
              if (cmp_ge) begin
                res_q_next = '{ok: 1'b1, handle: '0, pool: '0};
                state_next = mpba_pkg::S_RESP;
              end else begin
                pool_raddr = mpba_pkg::IDX_W'(req.free_handle);
                state_next = mpba_pkg::S_FREE_READ;
              end
            end
            default: begin
              res_q_next = '{ok: 1'b0, handle: '0, pool: '0};
              state_next = mpba_pkg::S_RESP;
            end
          endcase
        end
      end

      // one pool per cycle through the comparator
      mpba_pkg::S_GET_SCAN: begin
        cmp_a = mpba_pkg::OPND_W'(cfg.block_bytes[pool_q]);
        cmp_b = mpba_pkg::OPND_W'(len_q);
        if (cmp_ge && nonempty[pool_q]) begin
          link_raddr = head[pool_q];
          state_next = mpba_pkg::S_GET_POP;
        end else if (last_pool) begin
          res_q_next = '{ok: 1'b0, handle: '0, pool: '0};
          state_next = mpba_pkg::S_RESP;
        end else begin
          pool_q_next = pool_q + 1'b1;
        end
      end

      mpba_pkg::S_GET_POP: begin
        if (link_rdata[mpba_pkg::IDX_W]) begin
          head_next[pool_q] = link_rdata[mpba_pkg::IDX_W-1:0];
        end else begin
          nonempty_next[pool_q] = 1'b0;
        end
        res_q_next = '{ok: 1'b1, handle: mpba_pkg::HANDLE_W'(head[pool_q]), pool: pool_q};
        state_next = mpba_pkg::S_RESP;
      end

      // the freed entry becomes a tail: clear its link first
      mpba_pkg::S_FREE_READ: begin
        pool_q_next = pool_rdata;
        link_we     = 1'b1;
        link_waddr  = handle_q;
        link_wdata  = '0;
        state_next  = mpba_pkg::S_FREE_LINK;
      end

      mpba_pkg::S_FREE_LINK: begin
        if (nonempty[pool_q]) begin
          link_we    = 1'b1;
          link_waddr = tail[pool_q];
          link_wdata = {1'b1, handle_q};
        end else begin
          head_next[pool_q]     = handle_q;
          nonempty_next[pool_q] = 1'b1;
        end
        tail_next[pool_q] = handle_q;
        res_q_next        = '{ok: 1'b1, handle: '0, pool: '0};
        state_next        = mpba_pkg::S_RESP;
      end

      // capacity check of one pool; an overflowing pool ends the build
      mpba_pkg::S_INIT_POOL: begin
        cmp_a = mpba_pkg::OPND_W'(mpba_pkg::MAX_ENTRIES);
        cmp_b = mpba_pkg::OPND_W'(init_sum);
        if (cfg.entry_count[pool_q] == '0) begin
          if (last_pool) begin
            res_q_next = '{ok: 1'b1, handle: '0, pool: '0};
            state_next = mpba_pkg::S_RESP;
          end else begin
            pool_q_next = pool_q + 1'b1;
          end
        end else if (!cmp_ge) begin
          res_q_next = '{ok: 1'b1, handle: '0, pool: '0};
          state_next = mpba_pkg::S_RESP;
        end else begin
          head_next[pool_q]     = mpba_pkg::IDX_W'(base_q);
          tail_next[pool_q]     = mpba_pkg::IDX_W'(init_sum - 1'b1);
          nonempty_next[pool_q] = 1'b1;
          fill_idx_next         = mpba_pkg::IDX_W'(base_q);
          state_next            = mpba_pkg::S_INIT_FILL;
        end
      end

      // entries of a pool are consecutive: each links to the next, the last ends
      mpba_pkg::S_INIT_FILL: begin
        pool_we    = 1'b1;
        pool_waddr = fill_idx;
        pool_wdata = pool_q;
        link_we    = 1'b1;
        link_waddr = fill_idx;
        if (fill_idx == tail[pool_q]) begin
          link_wdata  = '0;
          base_q_next = mpba_pkg::CNT_W'(fill_idx) + 1'b1;
          if (last_pool) begin
            res_q_next = '{ok: 1'b1, handle: '0, pool: '0};
            state_next = mpba_pkg::S_RESP;
          end else begin
            pool_q_next = pool_q + 1'b1;
            state_next  = mpba_pkg::S_INIT_POOL;
          end
        end else begin
          link_wdata    = {1'b1, fill_idx + 1'b1};
          fill_idx_next = fill_idx + 1'b1;
        end
      end

      mpba_pkg::S_RESP: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = mpba_pkg::S_IDLE;
        end
      end

      default: state_next = mpba_pkg::S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data <= res_q;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.ok           = rsp_data.ok;
  assign rsp.grant_handle = rsp_data.handle;
  assign rsp.grant_pool   = rsp_data.pool;

  // a new result only ever comes out of the result stage
  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == mpba_pkg::S_RESP)
    else $error("result raised outside the result stage");

  // build walk never runs past the tail it set for the pool
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == mpba_pkg::S_INIT_FILL |-> fill_idx <= tail[pool_q])
    else $error("init fill passed the pool tail");

  // a failed command carries no grant
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.ok |-> rsp_data.handle == '0 && rsp_data.pool == '0)
    else $error("failed result carries a grant");

  // a pop only follows a hit on a non-empty pool
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == mpba_pkg::S_GET_POP |-> nonempty[pool_q] && $past(cmp_ge))
    else $error("pop from an empty or undersized pool");

endmodule
